/* src/mrco_pkg.sv */
// Shared types, constants and helper functions for the matroid rank and closure oracle.
`timescale 1ns / 1ps

package mrco_pkg;

  localparam int MASK_W           = 16;
  localparam int ELEM_W           = 5;
  localparam int RANK_W           = 5;
  localparam int KIND_W           = 2;
  localparam int MAX_ELEMENTS     = 16;
  localparam int DEF_MAX_BASES    = 256;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int ELEM_COUNT_RESET = 16;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic REG_IDX_ELEMENT_COUNT = 1'b0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic append;
    logic scan_f;
    logic scan_bit;
    logic rank_latch;
    logic bit_decide;
    logic bit_next;
    logic out_load;
  } mrco_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              scan_done;
    logic              bits_done;
    logic              bit_in_set;
  } mrco_stat_t;

  function automatic logic [RANK_W-1:0] popcount16(input logic [MASK_W-1:0] v);
    logic [RANK_W-1:0] c;
    c = '0;
    for (int k = 0; k < MASK_W; k++) begin
      c = c + RANK_W'(v[k]);
    end
    return c;
  endfunction

  // Number of elements the closure scans, saturated to the element and mask limits.
  function automatic logic [ELEM_W-1:0] elem_limit(input logic [ELEM_W-1:0] n);
    logic [ELEM_W-1:0] lim;
    lim = (MAX_ELEMENTS < MASK_W) ? ELEM_W'(MAX_ELEMENTS) : ELEM_W'(MASK_W);
    return (n > lim) ? lim : n;
  endfunction

endpackage

/* src/mrco_in_if.sv */
// Input channel interface: operation kind and set mask with valid/ready.
`timescale 1ns / 1ps

interface mrco_in_if import mrco_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [MASK_W-1:0] set_mask;

  modport source(output valid, kind, set_mask, input ready);
  modport sink(input valid, kind, set_mask, output ready);
endinterface

/* src/mrco_out_if.sv */
// Output channel interface: rank, closure and status with valid/ready.
`timescale 1ns / 1ps

interface mrco_out_if import mrco_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_value;
  logic [MASK_W-1:0] closure_mask;
  logic              status;

  modport source(output valid, rank_value, closure_mask, status, input ready);
  modport sink(input valid, rank_value, closure_mask, status, output ready);
endinterface

/* src/mrco_datapath.sv */
// Datapath: basis memory, rank scan engine, closure registers and result registers.
`timescale 1ns / 1ps

module mrco_datapath import mrco_pkg::*; #(
  parameter int MAX_BASES = DEF_MAX_BASES
) (
  input  logic              clk,
  input  logic              rst,
  input  mrco_cmd_t         cmd,
  output mrco_stat_t        stat,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [MASK_W-1:0] in_set_mask,
  input  logic [ELEM_W-1:0] element_count,
  output logic [RANK_W-1:0] rank_value,
  output logic [MASK_W-1:0] closure_mask,
  output logic              status
);

  localparam int CNT_W = $clog2(MAX_BASES + 1);
  localparam int IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;

  logic [MASK_W-1:0] basis_mem [MAX_BASES];
  logic [MASK_W-1:0] rd_data;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_addr;
  logic              scan_active;
  logic              rd_pend;
  logic [RANK_W-1:0] best;
  logic [MASK_W-1:0] cand;

  logic [KIND_W-1:0] kind_r;
  logic [MASK_W-1:0] f_r;
  logic [MASK_W-1:0] cl_r;
  logic [RANK_W-1:0] r_r;
  logic              status_r;
  logic [ELEM_W-1:0] i_cnt;

  logic              full;
  logic              scan_start;
  logic [MASK_W-1:0] bit_mask;
  logic [ELEM_W-1:0] n_sat;
  logic [RANK_W-1:0] pc;

  assign full       = (count == CNT_W'(MAX_BASES));
  assign scan_start = cmd.scan_f | cmd.scan_bit;
  assign bit_mask   = MASK_W'(1) << i_cnt[$clog2(MASK_W)-1:0];
  assign n_sat      = elem_limit(element_count);
  assign pc         = popcount16(cand & rd_data);

  assign stat.kind       = kind_r;
  assign stat.scan_done  = !scan_active && !rd_pend;
  assign stat.bits_done  = (i_cnt >= n_sat);
  assign stat.bit_in_set = |(cl_r & bit_mask);

  // Single write port for appends, single registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      basis_mem[count[IDX_W-1:0]] <= f_r;
    end
    rd_data <= basis_mem[scan_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      scan_active <= 1'b0;
      rd_pend     <= 1'b0;
      scan_addr   <= '0;
      best        <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + 1'b1;
      end
      if (scan_start) begin
        scan_addr   <= '0;
        scan_active <= (count != '0);
        rd_pend     <= 1'b0;
        best        <= '0;
      end else begin
        rd_pend <= scan_active;
        if (scan_active) begin
          scan_addr <= scan_addr + 1'b1;
          if (CNT_W'(scan_addr + 1'b1) == count) begin
            scan_active <= 1'b0;
          end
        end
        // Read data arrives in the cycle after its address is presented.
        if (rd_pend && (pc > best)) begin
          best <= pc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      f_r      <= in_set_mask;
      cl_r     <= in_set_mask;
      i_cnt    <= '0;
      status_r <= STATUS_OK;
    end
    if (cmd.append && full) begin
      status_r <= STATUS_FULL;
    end
    if (scan_start) begin
      cand <= cmd.scan_f ? f_r : (cl_r | bit_mask);
    end
    if (cmd.rank_latch) begin
      r_r <= best;
    end
    // The element stays only if adding it did not raise the rank.
    if (cmd.bit_decide && (best <= r_r)) begin
      cl_r <= cl_r | bit_mask;
    end
    if (cmd.bit_next) begin
      i_cnt <= i_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      rank_value   <= (kind_r == KIND_QUERY) ? r_r : '0;
      closure_mask <= (kind_r == KIND_QUERY) ? cl_r : '0;
      status       <= status_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_active |-> (scan_addr < count))
    else $error("scan address beyond stored bases");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BASES))
    else $error("basis count exceeds table depth");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.append && full) |=> (status_r == STATUS_FULL))
    else $error("dropped append not flagged");
`endif

endmodule

/* src/mrco_ctrl.sv */
// Controller state machine sequencing clear, append and query transactions.
`timescale 1ns / 1ps

module mrco_ctrl import mrco_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mrco_stat_t stat,
  output mrco_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    RANK_SCAN,
    CLOSE_CHECK,
    CLOSE_SCAN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = EXEC;
        end
      end
      EXEC: begin
        unique case (stat.kind)
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = FINISH;
          end
          KIND_APPEND: begin
            cmd.append = 1'b1;
            state_next = FINISH;
          end
          KIND_QUERY: begin
            cmd.scan_f = 1'b1;
            state_next = RANK_SCAN;
          end
          default: state_next = FINISH;
        endcase
      end
      RANK_SCAN: begin
        if (stat.scan_done) begin
          cmd.rank_latch = 1'b1;
          state_next     = CLOSE_CHECK;
        end
      end
      CLOSE_CHECK: begin
        priority if (stat.bits_done) begin
          state_next = FINISH;
        end else if (stat.bit_in_set) begin
          cmd.bit_next = 1'b1;
        end else begin
          cmd.scan_bit = 1'b1;
          state_next   = CLOSE_SCAN;
        end
      end
      CLOSE_SCAN: begin
        if (stat.scan_done) begin
          cmd.bit_decide = 1'b1;
          cmd.bit_next   = 1'b1;
          state_next     = CLOSE_CHECK;
        end
      end
      FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_scan_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_f || cmd.scan_bit) |-> stat.scan_done)
    else $error("scan started while previous scan running");
`endif

endmodule

/* src/matroid_rank_closure_oracle.sv */
// Top level: matroid rank and closure oracle with APB register port.
// Clear, append and unused kinds pass through EXEC and FINISH to the result register.
// A query runs one rank scan of F, then one closure scan for each scanned element
// not in F; each rank scan reads one basis per cycle from the registered read port
// of the basis memory. One transaction is in flight at a time; the output register
// holds a result while the next transaction is accepted.
// Synchronous reset empties the basis table (count only) and sets element_count to 16.
`timescale 1ns / 1ps

module matroid_rank_closure_oracle import mrco_pkg::*; #(
  parameter int MAX_BASES = DEF_MAX_BASES
) (
  input  logic                  clk,
  input  logic                  rst,
  mrco_in_if.sink               in_ch,
  mrco_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ELEM_W-1:0] element_count;
  mrco_cmd_t         cmd;
  mrco_stat_t        stat;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_IDX_ELEMENT_COUNT);
  assign prdata  = reg_sel ? APB_DATA_W'(element_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEM_W'(ELEM_COUNT_RESET);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      element_count <= pwdata[ELEM_W-1:0];
    end
  end

  mrco_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrco_datapath #(
    .MAX_BASES (MAX_BASES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_ch.kind),
    .in_set_mask   (in_ch.set_mask),
    .element_count (element_count),
    .rank_value    (out_ch.rank_value),
    .closure_mask  (out_ch.closure_mask),
    .status        (out_ch.status)
  );

endmodule
